// File: rtl/core/cssc_pkg.sv
package cssc_pkg;

   typedef struct packed {
      logic [7:0] script_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic [15:0] error_offset;
   } rsp_type;

   typedef struct packed {
      logic [3:0] err;
      logic [3:0] flags;
   } flag_judge_type;

   localparam logic [9:0] ARG_LIMIT_RESET = 10'd1000;
   localparam logic [15:0] ID_MAX = 16'd65535;

   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_DUP_FLAG      = 4'd1;
   localparam logic [3:0] ERR_NL_NO_PRINT   = 4'd2;
   localparam logic [3:0] ERR_UNKNOWN_FLAG  = 4'd3;
   localparam logic [3:0] ERR_PRINT_SH      = 4'd4;
   localparam logic [3:0] ERR_PRINT_NULL    = 4'd5;
   localparam logic [3:0] ERR_MISSING_GT    = 4'd6;
   localparam logic [3:0] ERR_HASH_AT_END   = 4'd7;
   localparam logic [3:0] ERR_BAD_NUMBER    = 4'd8;
   localparam logic [3:0] ERR_EMPTY_NAME    = 4'd9;
   localparam logic [3:0] ERR_NO_BRACE      = 4'd10;
   localparam logic [3:0] ERR_NO_BRACKET    = 4'd11;
   localparam logic [3:0] ERR_BAD_HASH      = 4'd12;
   localparam logic [3:0] ERR_TOO_MANY_ARGS = 4'd13;

   localparam logic [3:0] F_PRINT = 4'b0001;
   localparam logic [3:0] F_NL    = 4'b0010;
   localparam logic [3:0] F_NULL  = 4'b0100;
   localparam logic [3:0] F_SH    = 4'b1000;

   localparam logic [39:0] TOK_PRINT = 40'h7072696E74;
   localparam logic [39:0] TOK_NULL  = 40'h006E756C6C;
   localparam logic [39:0] TOK_SH    = 40'h0000217368;
   localparam logic [39:0] TOK_NL    = 40'h0000216E6C;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BIG_M  = 8'h4D;
   localparam logic [7:0] CH_N      = 8'h6E;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic flag_judge_type judge_flag(input logic [39:0] tok,
                                                 input logic [2:0]  len,
                                                 input logic [3:0]  seen);
      flag_judge_type res;
      logic [3:0]     bit_sel;
      logic [3:0]     merged;
      res.err   = ERR_NONE;
      res.flags = seen;
      bit_sel   = 4'b0000;
      priority if (len == 3'd5 && tok == TOK_PRINT) begin
         bit_sel = F_PRINT;
      end else if (len == 3'd4 && tok == TOK_NULL) begin
         bit_sel = F_NULL;
      end else if (len == 3'd3 && tok == TOK_SH) begin
         bit_sel = F_SH;
      end else if (len == 3'd3 && tok == TOK_NL) begin
         bit_sel = F_NL;
      end else begin
         bit_sel = 4'b0000;
      end
      merged = seen | bit_sel;
      priority if (bit_sel == 4'b0000) begin
         res.err = ERR_UNKNOWN_FLAG;
      end else if ((seen & bit_sel) != 4'b0000) begin
         res.err = ERR_DUP_FLAG;
      end else if (bit_sel == F_NL && (seen & F_PRINT) == 4'b0000) begin
         res.err = ERR_NL_NO_PRINT;
      end else begin
         res.flags = merged;
         if ((merged & F_PRINT) != 4'b0000 && (merged & F_SH) != 4'b0000) begin
            res.err = ERR_PRINT_SH;
         end else if ((merged & F_PRINT) != 4'b0000 && (merged & F_NULL) != 4'b0000) begin
            res.err = ERR_PRINT_NULL;
         end else begin
            res.err = ERR_NONE;
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/core/callout_script_syntax_checker_core.sv
// Command script syntax checker.
//
// The req channel carries one script byte per transaction, with last_char
// set on the final byte. The rsp channel carries exactly one transaction per
// script, holding the first error code found and its byte offset (zero when
// the script is correct). The csr channel writes the argument limit; it is
// always ready and must only be used while no script is in progress.
//
// One byte is accepted every cycle unless a final byte is held in the input
// register (see below). Each byte is first captured in the input register and
// is then parsed by single-pass logic that updates the parser state; the result
// of a script is registered, so it appears on rsp in the cycle after its final byte is parsed.
//
// Reset returns the parser to the start of a script and sets the argument
// limit to 1000. While a result waits on a stalled receiver, bytes of the
// next script keep flowing; only the final byte of that next script is held
// in the input register until the waiting result has been taken.
module callout_script_syntax_checker_core
   import cssc_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_data
);

   localparam logic [3:0] PH_LEAD       = 4'd0;
   localparam logic [3:0] PH_FLAG       = 4'd1;
   localparam logic [3:0] PH_FLAG_SKIP  = 4'd2;
   localparam logic [3:0] PH_GAP        = 4'd3;
   localparam logic [3:0] PH_BODY       = 4'd4;
   localparam logic [3:0] PH_HASH       = 4'd5;
   localparam logic [3:0] PH_DEC        = 4'd6;
   localparam logic [3:0] PH_BR_FIRST   = 4'd7;
   localparam logic [3:0] PH_BR_DIGITS  = 4'd8;
   localparam logic [3:0] PH_NAME_FIRST = 4'd9;
   localparam logic [3:0] PH_BR_NAME    = 4'd10;
   localparam logic [3:0] PH_SQ_FIRST   = 4'd11;
   localparam logic [3:0] PH_SQ_NAME    = 4'd12;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   logic                   s1_valid_ff, s1_valid_in;
   req_type                s1_data_ff;
   logic                   s1_advance;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [9:0]             limit_ff;

   logic [3:0]             phase_ff, phase_in;
   logic [39:0]            token_ff, token_in;
   logic [2:0]             token_len_ff, token_len_in;
   logic [3:0]             flags_ff, flags_in;
   logic [15:0]            id_ff, id_in;
   logic [9:0]             arg_count_ff, arg_count_in;
   logic                   group_ff, group_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [3:0]             err_ff, err_in;
   logic [OFFSET_BITS-1:0] err_off_ff, err_off_in;
   logic [OFFSET_BITS-1:0] star_ff, star_in;

   logic [7:0]             c;
   logic                   do_start, do_digit;
   logic [3:0]             digit_next;
   logic [19:0]            digit_val;
   flag_judge_type         judge_now, judge_end;

   function automatic logic [3:0] body_phase(input logic [7:0] ch, input logic grp);
      logic [3:0] ph;
      priority if ((!grp && is_ws(ch)) || (grp && ch == CH_GT)) begin
         ph = PH_GAP;
      end else if (ch == CH_HASH) begin
         ph = PH_HASH;
      end else begin
         ph = PH_BODY;
      end
      return ph;
   endfunction

   assign c          = s1_data_ff.script_char;
   assign s1_advance = s1_valid_ff && !(s1_data_ff.last_char && rsp_valid_ff && !rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign digit_val = ({4'b0000, id_ff} << 3) + ({4'b0000, id_ff} << 1) + 20'(c[3:0]);
   assign judge_now = judge_flag(token_ff, token_len_ff, flags_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      token_in     = token_ff;
      token_len_in = token_len_ff;
      flags_in     = flags_ff;
      id_in        = id_ff;
      arg_count_in = arg_count_ff;
      group_in     = group_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      err_off_in   = err_off_ff;
      star_in      = star_ff;
      do_start     = 1'b0;
      do_digit     = 1'b0;
      digit_next   = phase_ff;
      judge_end    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (s1_advance) begin
         pos_in = (pos_ff == OFFSET_MAX) ? pos_ff : pos_ff + 1'b1;
         if (err_ff == ERR_NONE) begin
            unique case (phase_ff)
               PH_LEAD, PH_FLAG_SKIP: begin
                  if (is_ws(c)) begin
                     phase_in = phase_ff;
                  end else if (c == CH_STAR) begin
                     star_in      = pos_ff;
                     token_in     = '0;
                     token_len_in = '0;
                     phase_in     = PH_FLAG;
                  end else begin
                     do_start = 1'b1;
                  end
               end
               PH_FLAG: begin
                  if (is_ws(c) || c == CH_NUL) begin
                     flags_in = judge_now.flags;
                     if (judge_now.err != ERR_NONE) begin
                        err_in     = judge_now.err;
                        err_off_in = star_ff;
                     end else if (is_ws(c)) begin
                        phase_in = PH_FLAG_SKIP;
                     end else begin
                        do_start = 1'b1;
                     end
                  end else if (token_len_ff < 3'd5) begin
                     token_in     = {token_ff[31:0], c};
                     token_len_in = token_len_ff + 3'd1;
                  end else begin
                     token_len_in = 3'd6;
                  end
               end
               PH_GAP: begin
                  if (!is_ws(c)) begin
                     do_start = 1'b1;
                  end
               end
               PH_BODY: begin
                  phase_in = body_phase(c, group_ff);
               end
               PH_HASH: begin
                  if (is_digit(c)) begin
                     id_in    = 16'(c[3:0]);
                     phase_in = PH_DEC;
                  end else if (c == CH_LBRACE) begin
                     id_in    = '0;
                     phase_in = PH_BR_FIRST;
                  end else if (c == CH_LBRACK) begin
                     phase_in = PH_SQ_FIRST;
                  end else if (c == CH_HASH || c == CH_LT || c == CH_GT ||
                               c == CH_BIG_M || c == CH_N) begin
                     phase_in = PH_BODY;
                  end else begin
                     err_in     = ERR_BAD_HASH;
                     err_off_in = pos_ff;
                  end
               end
               PH_DEC: begin
                  if (is_digit(c)) begin
                     do_digit   = 1'b1;
                     digit_next = PH_DEC;
                  end else begin
                     phase_in = body_phase(c, group_ff);
                  end
               end
               PH_BR_FIRST: begin
                  if (is_digit(c)) begin
                     do_digit   = 1'b1;
                     digit_next = PH_BR_DIGITS;
                  end else begin
                     err_in     = ERR_BAD_NUMBER;
                     err_off_in = pos_ff;
                  end
               end
               PH_BR_DIGITS: begin
                  if (c == CH_RBRACE) begin
                     phase_in = PH_BODY;
                  end else if (c == CH_COMMA) begin
                     phase_in = PH_NAME_FIRST;
                  end else if (is_digit(c)) begin
                     do_digit   = 1'b1;
                     digit_next = PH_BR_DIGITS;
                  end else begin
                     err_in     = ERR_BAD_NUMBER;
                     err_off_in = pos_ff;
                  end
               end
               PH_NAME_FIRST: begin
                  if (c == CH_RBRACE) begin
                     err_in     = ERR_EMPTY_NAME;
                     err_off_in = pos_ff;
                  end else begin
                     phase_in = PH_BR_NAME;
                  end
               end
               PH_BR_NAME: begin
                  if (c == CH_RBRACE) begin
                     phase_in = PH_BODY;
                  end
               end
               PH_SQ_FIRST: begin
                  if (c == CH_RBRACK) begin
                     err_in     = ERR_EMPTY_NAME;
                     err_off_in = pos_ff;
                  end else begin
                     phase_in = PH_SQ_NAME;
                  end
               end
               PH_SQ_NAME: begin
                  if (c == CH_RBRACK) begin
                     phase_in = PH_BODY;
                  end
               end
               default: begin
                  phase_in = PH_LEAD;
               end
            endcase

            if (do_start) begin
               if (arg_count_ff >= limit_ff) begin
                  err_in     = ERR_TOO_MANY_ARGS;
                  err_off_in = pos_ff;
               end else begin
                  arg_count_in = arg_count_ff + 10'd1;
                  if (c == CH_LT) begin
                     group_in = 1'b1;
                     phase_in = PH_BODY;
                  end else begin
                     group_in = 1'b0;
                     phase_in = body_phase(c, 1'b0);
                  end
               end
            end

            if (do_digit) begin
               if (digit_val > 20'(ID_MAX)) begin
                  err_in     = ERR_BAD_NUMBER;
                  err_off_in = pos_ff;
               end else begin
                  id_in    = digit_val[15:0];
                  phase_in = digit_next;
               end
            end
         end

         if (err_in == ERR_NONE && s1_data_ff.last_char) begin
            judge_end = judge_flag(token_in, token_len_in, flags_in);
            unique case (phase_in)
               PH_FLAG: begin
                  if (judge_end.err != ERR_NONE) begin
                     err_in     = judge_end.err;
                     err_off_in = star_in;
                  end
               end
               PH_BODY, PH_DEC: begin
                  if (group_in) begin
                     err_in     = ERR_MISSING_GT;
                     err_off_in = pos_in;
                  end
               end
               PH_HASH: begin
                  err_in     = ERR_HASH_AT_END;
                  err_off_in = pos_in;
               end
               PH_BR_FIRST, PH_BR_DIGITS: begin
                  err_in     = ERR_BAD_NUMBER;
                  err_off_in = pos_in;
               end
               PH_NAME_FIRST, PH_SQ_FIRST: begin
                  err_in     = ERR_EMPTY_NAME;
                  err_off_in = pos_in;
               end
               PH_BR_NAME: begin
                  err_in     = ERR_NO_BRACE;
                  err_off_in = pos_in;
               end
               PH_SQ_NAME: begin
                  err_in     = ERR_NO_BRACKET;
                  err_off_in = pos_in;
               end
               default: begin
                  err_in = ERR_NONE;
               end
            endcase
         end

         if (s1_data_ff.last_char) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.error_code   = err_in;
            rsp_data_in.error_offset = (err_in != ERR_NONE) ? 16'(err_off_in) : 16'd0;
            phase_in     = PH_LEAD;
            token_in     = '0;
            token_len_in = '0;
            flags_in     = '0;
            id_in        = '0;
            arg_count_in = 10'd1;
            group_in     = 1'b0;
            pos_in       = '0;
            err_in       = ERR_NONE;
            err_off_in   = '0;
            star_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= ARG_LIMIT_RESET;
         phase_ff     <= PH_LEAD;
         token_ff     <= '0;
         token_len_ff <= '0;
         flags_ff     <= '0;
         id_ff        <= '0;
         arg_count_ff <= 10'd1;
         group_ff     <= 1'b0;
         pos_ff       <= '0;
         err_ff       <= ERR_NONE;
         err_off_ff   <= '0;
         star_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         phase_ff     <= phase_in;
         token_ff     <= token_in;
         token_len_ff <= token_len_in;
         flags_ff     <= flags_in;
         id_ff        <= id_in;
         arg_count_ff <= arg_count_in;
         group_ff     <= group_in;
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         err_off_ff   <= err_off_in;
         star_ff      <= star_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_ok_has_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error_code == ERR_NONE) |-> rsp_data_ff.error_offset == 16'd0)
      else $error("A result without an error carries a non-zero offset.");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_data_ff.last_char) |=>
         (phase_ff == PH_LEAD && err_ff == ERR_NONE && pos_ff == '0 && arg_count_ff == 10'd1))
      else $error("Parser state was not cleared after the final byte of a script.");

   a_first_error_held: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE && !(s1_advance && s1_data_ff.last_char)) |=>
         (err_ff == $past(err_ff) && err_off_ff == $past(err_off_ff)))
      else $error("A latched error changed before the end of the script.");

endmodule
